FILE: rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("implication check failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: rtl/vdk3_pkg.sv
// types, trellis tables and constants of the k3 rate-1/2 viterbi decoder
package vdk3_pkg;

  localparam int unsigned MetricW  = 6;
  localparam int unsigned PathW    = 8;
  localparam int unsigned CountW   = 4;
  localparam int unsigned NumState = 4;

  localparam logic [MetricW-1:0] MetricMax = 6'd63;
  localparam logic [MetricW-1:0] ThrReset  = 6'd3;

  // predecessor of each state for its two branches
  localparam logic [1:0] TrPred [NumState][2] = '{
    '{2'd0, 2'd1}, '{2'd2, 2'd3}, '{2'd0, 2'd1}, '{2'd2, 2'd3}
  };

  // expected code pair {a, b} on each branch
  localparam logic [1:0] TrExp [NumState][2] = '{
    '{2'b00, 2'b11}, '{2'b10, 2'b01}, '{2'b11, 2'b00}, '{2'b01, 2'b10}
  };

  // one queue entry: branch distances to every code pair plus block bookkeeping
  typedef struct packed {
    logic [3:0][1:0]    hdist;     // hamming distance indexed by {exp_a, exp_b}
    logic [PathW-1:0]   set_mask;  // one-hot position of the decoded bit, zero past bit 7
    logic [CountW-1:0]  count;     // pairs in the block including this one
    logic               last;      // closes the block
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

FILE: rtl/vdk3_if.sv
// handshake channels for received symbol pairs and decoded blocks
interface vdk3_sym_if;
  logic valid;
  logic ready;
  logic bit_a;
  logic bit_b;
  logic end_of_sequence;

  modport source(output valid, bit_a, bit_b, end_of_sequence, input ready);
  modport sink(input valid, bit_a, bit_b, end_of_sequence, output ready);
endinterface

interface vdk3_dec_if import vdk3_pkg::*;;
  logic               valid;
  logic               ready;
  logic [PathW-1:0]   decoded_bits;
  logic [CountW-1:0]  bit_count;
  logic [MetricW-1:0] best_metric;
  logic               error_flag;

  modport source(output valid, decoded_bits, bit_count, best_metric, error_flag,
                 input ready);
  modport sink(input valid, decoded_bits, bit_count, best_metric, error_flag,
               output ready);
endinterface

FILE: rtl/viterbi_decoder_k3_rate_half_unit.sv
// hard-decision viterbi decoder, 4 states, rate 1/2, block-wise register exchange
// throughput: one symbol pair per cycle while the queue is not full, set by the combinational acs step
// the block word passes the queue and the output register on its way to dec_o
// the two-entry queue lets the input run on while a finished word waits on dec_o
// reset: threshold 3, state 0 metric 0 and others min(4*BLOCK_LEN, 63), queue empty
module viterbi_decoder_k3_rate_half_unit import vdk3_pkg::*; #(
  parameter int unsigned BLOCK_LEN = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  vdk3_sym_if.sink           sym_i,
  vdk3_dec_if.source         dec_o,
  input  logic               cfg_we_i,
  input  logic [MetricW-1:0] cfg_data_i
);

  logic [MetricW-1:0] thr_q, thr_d;
  logic               q_push;
  logic               q_pop;
  q_entry_t           q_wr_entry;
  q_entry_t           q_head;
  q_stat_t            q_stat;

  assign thr_d = cfg_we_i ? cfg_data_i : thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrReset;
    end else begin
      thr_q <= thr_d;
    end
  end

  vdk3_front #(.BLOCK_LEN(BLOCK_LEN)) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .sym_i     (sym_i),
    .q_stat_i  (q_stat),
    .q_push_o  (q_push),
    .q_entry_o (q_wr_entry)
  );

  vdk3_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_wr_entry),
    .pop_i   (q_pop),
    .stat_o  (q_stat),
    .head_o  (q_head)
  );

  vdk3_back #(.BLOCK_LEN(BLOCK_LEN)) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_stat_i (q_stat),
    .q_head_i (q_head),
    .q_pop_o  (q_pop),
    .thr_i    (thr_q),
    .dec_o    (dec_o)
  );

endmodule

FILE: rtl/vdk3_front.sv
// front end: takes symbol pairs, works out branch distances and block position
module vdk3_front import vdk3_pkg::*; #(
  parameter int unsigned BLOCK_LEN = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  vdk3_sym_if.sink      sym_i,
  input  q_stat_t       q_stat_i,
  output logic          q_push_o,
  output q_entry_t      q_entry_o
);

  localparam int unsigned CntW = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW:0]   cnt_inc;
  logic            last;

  assign sym_i.ready = !q_stat_i.full;
  assign q_push_o    = sym_i.valid && !q_stat_i.full;

  assign cnt_inc = {1'b0, cnt_q} + 1'b1;
  assign last    = (cnt_q == CntW'(BLOCK_LEN - 1)) || sym_i.end_of_sequence;

  always_comb begin
    for (int e = 0; e < 4; e++) begin
      q_entry_o.hdist[e] = {1'b0, sym_i.bit_a ^ e[1]} + {1'b0, sym_i.bit_b ^ e[0]};
    end
    // positions past bit 7 shift out of the mask
    q_entry_o.set_mask = PathW'(1) << cnt_q;
    q_entry_o.count    = CountW'(cnt_inc);
    q_entry_o.last     = last;
  end

  always_comb begin
    cnt_d = cnt_q;
    if (q_push_o) begin
      cnt_d = last ? '0 : CntW'(cnt_inc);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

FILE: rtl/vdk3_queue.sv
// two-entry queue between front and back ends
module vdk3_queue import vdk3_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  q_entry_t entry_i,
  input  logic     pop_i,
  output q_stat_t  stat_o,
  output q_entry_t head_o
);

  q_entry_t   mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;

  assign stat_o.full  = (fill_q == 2'd2);
  assign stat_o.empty = (fill_q == 2'd0);
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i  ? !rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

endmodule

FILE: rtl/vdk3_back.sv
// back end: add-compare-select, register-exchange survivors and block output
module vdk3_back import vdk3_pkg::*; #(
  parameter int unsigned BLOCK_LEN = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  q_stat_t            q_stat_i,
  input  q_entry_t           q_head_i,
  output logic               q_pop_o,
  input  logic [MetricW-1:0] thr_i,
  vdk3_dec_if.source         dec_o
);

  localparam int unsigned StartRaw = 4 * BLOCK_LEN;
  localparam logic [MetricW-1:0] StartMetric =
    (StartRaw > 63) ? MetricMax : MetricW'(StartRaw);

  logic [MetricW-1:0] pm_q   [NumState];
  logic [MetricW-1:0] pm_d   [NumState];
  logic [PathW-1:0]   surv_q [NumState];
  logic [PathW-1:0]   surv_d [NumState];
  logic [MetricW-1:0] new_pm   [NumState];
  logic [PathW-1:0]   new_surv [NumState];
  logic [MetricW-1:0] cand [NumState][2];
  logic [1:0]         best;

  logic               out_valid_q, out_valid_d;
  logic [PathW-1:0]   out_bits_q, out_bits_d;
  logic [CountW-1:0]  out_count_q, out_count_d;
  logic [MetricW-1:0] out_metric_q, out_metric_d;
  logic               out_err_q, out_err_d;

  assign q_pop_o = !q_stat_i.empty &&
                   (!q_head_i.last || !out_valid_q || dec_o.ready);

  // add-compare-select for all four states
  always_comb begin
    logic [MetricW:0] sum;
    logic             pick;
    for (int s = 0; s < NumState; s++) begin
      for (int k = 0; k < 2; k++) begin
        sum        = {1'b0, pm_q[TrPred[s][k]]} + {5'b0, q_head_i.hdist[TrExp[s][k]]};
        cand[s][k] = sum[MetricW] ? MetricMax : sum[MetricW-1:0];
      end
      // ties keep the first predecessor
      pick        = cand[s][0] > cand[s][1];
      new_pm[s]   = pick ? cand[s][1] : cand[s][0];
      new_surv[s] = surv_q[TrPred[s][pick]] | ((s >= 2) ? q_head_i.set_mask : '0);
    end
  end

  // lowest metric wins, lowest index on ties
  always_comb begin
    best = 2'd0;
    for (int s = 1; s < NumState; s++) begin
      if (new_pm[s] < new_pm[best]) begin
        best = 2'(s);
      end
    end
  end

  always_comb begin
    for (int s = 0; s < NumState; s++) begin
      pm_d[s]   = pm_q[s];
      surv_d[s] = surv_q[s];
    end
    out_valid_d  = out_valid_q && !dec_o.ready;
    out_bits_d   = out_bits_q;
    out_count_d  = out_count_q;
    out_metric_d = out_metric_q;
    out_err_d    = out_err_q;
    if (q_pop_o) begin
      if (q_head_i.last) begin
        for (int s = 0; s < NumState; s++) begin
          pm_d[s]   = (s == 0) ? '0 : StartMetric;
          surv_d[s] = '0;
        end
        out_valid_d  = 1'b1;
        out_bits_d   = new_surv[best];
        out_count_d  = q_head_i.count;
        out_metric_d = new_pm[best];
        out_err_d    = new_pm[best] >= thr_i;
      end else begin
        for (int s = 0; s < NumState; s++) begin
          pm_d[s]   = new_pm[s];
          surv_d[s] = new_surv[s];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NumState; s++) begin
        pm_q[s]   <= (s == 0) ? '0 : StartMetric;
        surv_q[s] <= '0;
      end
      out_valid_q <= 1'b0;
    end else begin
      pm_q        <= pm_d;
      surv_q      <= surv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_bits_q   <= out_bits_d;
    out_count_q  <= out_count_d;
    out_metric_q <= out_metric_d;
    out_err_q    <= out_err_d;
  end

  assign dec_o.valid        = out_valid_q;
  assign dec_o.decoded_bits = out_bits_q;
  assign dec_o.bit_count    = out_count_q;
  assign dec_o.best_metric  = out_metric_q;
  assign dec_o.error_flag   = out_err_q;

endmodule

FILE: rtl/vdk3_checker.sv
// port-level checks of the decoder, bound to the top level
`include "assert_macros.svh"

module vdk3_checker import vdk3_pkg::*; #(
  parameter int unsigned BLOCK_LEN = 8
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               cfg_we_i,
  input logic [MetricW-1:0] cfg_data_i,
  input logic               dec_valid_i,
  input logic               dec_ready_i,
  input logic [PathW-1:0]   dec_bits_i,
  input logic [CountW-1:0]  dec_count_i,
  input logic [MetricW-1:0] dec_metric_i,
  input logic               dec_err_i
);

  localparam bit NoWrap = (BLOCK_LEN < 16);

  logic [MetricW-1:0] thr_q;
  logic               narrow;

  // shadow of the threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrReset;
    end else if (cfg_we_i) begin
      thr_q <= cfg_data_i;
    end
  end

  assign narrow = NoWrap && (dec_count_i < CountW'(PathW));

  `ASSERT_NEXT(a_dec_hold, clk_i, rst_ni, dec_valid_i && !dec_ready_i, dec_valid_i && $stable(dec_bits_i) && $stable(dec_count_i) && $stable(dec_metric_i))
  `ASSERT_IMPLY(a_err_flag, clk_i, rst_ni, dec_valid_i, dec_err_i == (dec_metric_i >= thr_q))
  `ASSERT_IMPLY(a_high_bits_zero, clk_i, rst_ni, dec_valid_i && narrow, (dec_bits_i >> dec_count_i) == '0)
  `ASSERT_IMPLY(a_metric_bound, clk_i, rst_ni, dec_valid_i && NoWrap, dec_count_i != '0 && {1'b0, dec_metric_i} <= {2'b0, dec_count_i, 1'b0})

endmodule

bind viterbi_decoder_k3_rate_half_unit vdk3_checker #(.BLOCK_LEN(BLOCK_LEN)) u_vdk3_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .cfg_we_i     (cfg_we_i),
  .cfg_data_i   (cfg_data_i),
  .dec_valid_i  (dec_o.valid),
  .dec_ready_i  (dec_o.ready),
  .dec_bits_i   (dec_o.decoded_bits),
  .dec_count_i  (dec_o.bit_count),
  .dec_metric_i (dec_o.best_metric),
  .dec_err_i    (dec_o.error_flag)
);

FILE: tb/viterbi_decoder_k3_rate_half_unit_tb.sv
// testbench of the k3 rate-1/2 viterbi decoder: encoded and noisy pairs checked against a predictor
module viterbi_decoder_k3_rate_half_unit_tb;
  import vdk3_pkg::*;

  localparam int unsigned BlockLen    = 8;
  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned PhaseItems  = 190;
  localparam int unsigned NumPhases   = 6;
  localparam int unsigned SettleGap   = 8;
  localparam int unsigned StartMetric = (4 * BlockLen > 63) ? 63 : 4 * BlockLen;
  localparam logic [MetricW:0]   SatLevel   = 7'd63;
  localparam logic [MetricW-1:0] ThrAtReset = 6'd3;

  // predecessors and expected {a, b} of the two branches into each state
  localparam int unsigned PredTab [4][2] = '{'{0, 1}, '{2, 3}, '{0, 1}, '{2, 3}};
  localparam logic [1:0]  CodeTab [4][2] = '{
    '{2'b00, 2'b11}, '{2'b10, 2'b01}, '{2'b11, 2'b00}, '{2'b01, 2'b10}
  };

  typedef struct packed {
    logic a;
    logic b;
    logic eos;
  } sym_pair_t;

  typedef struct packed {
    logic [PathW-1:0]   decoded_bits;
    logic [CountW-1:0]  bit_count;
    logic [MetricW-1:0] best_metric;
    logic               error_flag;
  } dec_word_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we;
  logic [MetricW-1:0] cfg_data;

  vdk3_sym_if sym_ch ();
  vdk3_dec_if dec_ch ();

  viterbi_decoder_k3_rate_half_unit #(
    .BLOCK_LEN (BlockLen)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sym_i      (sym_ch),
    .dec_o      (dec_ch),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data)
  );

  // predictor state
  logic [MetricW-1:0] acc_metric [4];
  logic [PathW-1:0]   surv [4];
  int unsigned        pairs_in_block;
  logic [MetricW-1:0] thr_q;

  sym_pair_t   pairs_to_send [$];
  dec_word_t   blocks_due [$];
  int unsigned pairs_queued;
  int unsigned err_cnt;

  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned rdy_mode;
  int unsigned rdy_left;
  int unsigned rdy_phase;
  int unsigned idle_cycles;

  function automatic void restart_block();
    int s;
    for (s = 0; s < 4; s++) begin
      acc_metric[s] = (s == 0) ? '0 : MetricW'(StartMetric);
      surv[s]       = '0;
    end
    pairs_in_block = 0;
  endfunction

  // one add-compare-select step; returns 1 when the pair closes a block
  function automatic bit acs_step(input logic a, input logic b, input logic eos,
                                  output dec_word_t w);
    logic [MetricW-1:0] nm [4];
    logic [PathW-1:0]   np [4];
    logic [MetricW:0]   m0;
    logic [MetricW:0]   m1;
    logic [1:0]         e0;
    logic [1:0]         e1;
    logic [PathW:0]     mask;
    int unsigned        pw;
    int unsigned        best;
    int unsigned        s;
    w = '0;
    for (s = 0; s < 4; s++) begin
      e0 = CodeTab[s][0];
      e1 = CodeTab[s][1];
      m0 = acc_metric[PredTab[s][0]] + (a ^ e0[1]) + (b ^ e0[0]);
      m1 = acc_metric[PredTab[s][1]] + (a ^ e1[1]) + (b ^ e1[0]);
      if (m0 > SatLevel) m0 = SatLevel;
      if (m1 > SatLevel) m1 = SatLevel;
      // a tie keeps the first branch
      pw    = (m0 > m1) ? PredTab[s][1] : PredTab[s][0];
      nm[s] = (m0 > m1) ? m1[MetricW-1:0] : m0[MetricW-1:0];
      np[s] = surv[pw];
      if (s >= 2 && pairs_in_block < PathW) np[s][pairs_in_block] = 1'b1;
    end
    for (s = 0; s < 4; s++) begin
      acc_metric[s] = nm[s];
      surv[s]       = np[s];
    end
    pairs_in_block++;
    if (pairs_in_block < BlockLen && !eos) return 1'b0;
    best = 0;
    for (s = 1; s < 4; s++) begin
      if (acc_metric[s] < acc_metric[best]) best = s;
    end
    mask           = (pairs_in_block >= PathW) ? '1 : ((9'd1 << pairs_in_block) - 9'd1);
    w.decoded_bits = surv[best] & mask[PathW-1:0];
    w.bit_count    = pairs_in_block[CountW-1:0];
    w.best_metric  = acc_metric[best];
    w.error_flag   = (acc_metric[best] >= thr_q);
    restart_block();
    return 1'b1;
  endfunction

  task automatic push_pair(input logic a, input logic b, input logic eos);
    sym_pair_t p;
    p.a   = a;
    p.b   = b;
    p.eos = eos;
    pairs_to_send.push_back(p);
    pairs_queued++;
  endtask

  // every pair taken and every word out, then a settling wait for the pipeline
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pairs_to_send.size() != 0 || sym_ch.valid || blocks_due.size() != 0);
    repeat (SettleGap) @(negedge clk_i);
  endtask

  task automatic write_threshold(input logic [MetricW-1:0] v);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    thr_q     = v;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // driver: bursts of pairs with random gaps, holding a pair until it is taken
  always @(posedge clk_i) begin : drv
    sym_pair_t nxt;
    dec_word_t closed_word;
    logic      v_next;
    if (rst_ni) begin
      if (sym_ch.valid && sym_ch.ready) begin
        if (acs_step(sym_ch.bit_a, sym_ch.bit_b, sym_ch.end_of_sequence, closed_word))
          blocks_due.push_back(closed_word);
      end
      v_next = sym_ch.valid;
      if (!sym_ch.valid || sym_ch.ready) begin
        v_next = 1'b0;
        if (gap_left != 0) begin
          gap_left--;
        end else if (pairs_to_send.size() != 0) begin
          nxt = pairs_to_send.pop_front();
          sym_ch.bit_a           <= nxt.a;
          sym_ch.bit_b           <= nxt.b;
          sym_ch.end_of_sequence <= nxt.eos;
          v_next = 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end
      end
      sym_ch.valid <= v_next;
    end
  end

  // monitor: checks each decoded word and stalls on a pattern of its own
  always @(posedge clk_i) begin : mon
    dec_word_t due;
    logic      rdy;
    if (rst_ni) begin
      if (dec_ch.valid && dec_ch.ready) begin
        if (blocks_due.size() == 0) begin
          $error("decoded word with none due: bits %0h count %0d", dec_ch.decoded_bits,
                 dec_ch.bit_count);
          err_cnt++;
        end else begin
          due = blocks_due.pop_front();
          if (dec_ch.decoded_bits !== due.decoded_bits) begin
            $error("decoded_bits: expected %0h, got %0h", due.decoded_bits,
                   dec_ch.decoded_bits);
            err_cnt++;
          end
          if (dec_ch.bit_count !== due.bit_count) begin
            $error("bit_count: expected %0d, got %0d", due.bit_count, dec_ch.bit_count);
            err_cnt++;
          end
          if (dec_ch.best_metric !== due.best_metric) begin
            $error("best_metric: expected %0d, got %0d", due.best_metric,
                   dec_ch.best_metric);
            err_cnt++;
          end
          if (dec_ch.error_flag !== due.error_flag) begin
            $error("error_flag: expected %0b, got %0b", due.error_flag, dec_ch.error_flag);
            err_cnt++;
          end
        end
      end
      if (rdy_left == 0) begin
        rdy_mode  = $urandom_range(0, 3);
        rdy_left  = $urandom_range(8, 64);
        rdy_phase = 0;
      end else begin
        rdy_left--;
      end
      case (rdy_mode)
        0: begin
          rdy = 1'b1;
        end
        1: begin
          rdy = 1'($urandom_range(0, 1));
        end
        2: begin
          rdy = ($urandom_range(0, 3) == 0);
        end
        default: begin
          // ready while the phase is below 3, the phase wrapping to 0 after 4
          rdy       = (rdy_phase < 3);
          rdy_phase = (rdy_phase == 4) ? 0 : rdy_phase + 1;
        end
      endcase
      dec_ch.ready <= rdy;
    end
  end

  always @(posedge clk_i) begin
    if ((sym_ch.valid && sym_ch.ready) || (dec_ch.valid && dec_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("viterbi_decoder_k3_rate_half_unit_tb: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stim
    logic [MetricW-1:0] thr_plan [NumPhases];
    logic [1:0]         enc;
    logic [1:0]         ns;
    logic [1:0]         code;
    logic               u;
    logic               close;
    int unsigned        len;
    int unsigned        pf;
    int unsigned        target;
    int unsigned        ph;
    int unsigned        i;

    sym_ch.valid           = 1'b0;
    sym_ch.bit_a           = 1'b0;
    sym_ch.bit_b           = 1'b0;
    sym_ch.end_of_sequence = 1'b0;
    dec_ch.ready           = 1'b0;
    cfg_we                 = 1'b0;
    cfg_data               = '0;
    rst_ni                 = 1'b0;
    pairs_queued           = 0;
    err_cnt                = 0;
    burst_left             = 1;
    gap_left               = 0;
    rdy_mode               = 0;
    rdy_left               = 0;
    rdy_phase              = 0;
    idle_cycles            = 0;
    thr_q                  = ThrAtReset;
    restart_block();

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed, at the reset threshold
    // lone closing pairs; 10 and 01 leave a tie in the final choice
    push_pair(1'b0, 1'b0, 1'b1);
    push_pair(1'b0, 1'b1, 1'b1);
    push_pair(1'b1, 1'b0, 1'b1);
    push_pair(1'b1, 1'b1, 1'b1);
    // full block of 10 pairs, full length closes it with the flag set
    for (i = 0; i < BlockLen; i++) push_pair(1'b1, 1'b0, 1'b0);
    // full block of 11 pairs with end of sequence on its last pair
    for (i = 0; i < BlockLen; i++) push_pair(1'b1, 1'b1, i == BlockLen - 1);
    // short block one bit off a codeword, flushed early
    push_pair(1'b1, 1'b1, 1'b0);
    push_pair(1'b1, 1'b0, 1'b0);
    push_pair(1'b0, 1'b1, 1'b1);

    thr_plan[0] = 6'd0;
    thr_plan[1] = 6'd63;
    thr_plan[2] = 6'd1;
    thr_plan[3] = 6'($urandom_range(0, 63));
    thr_plan[4] = 6'd2;
    thr_plan[5] = 6'($urandom_range(2, 8));

    for (ph = 0; ph < NumPhases; ph++) begin
      wait_drained();
      write_threshold(thr_plan[ph]);
      target = pairs_queued + PhaseItems;
      while (pairs_queued < target) begin
        if ($urandom_range(0, 3) != 0) begin
          // encoded block from state 0 with sparse bit errors
          len   = ($urandom_range(0, 9) < 7) ? BlockLen : $urandom_range(1, BlockLen - 1);
          close = (len < BlockLen) || $urandom_range(0, 1);
          pf    = $urandom_range(0, 3);
          pf    = (pf == 3) ? 4 : pf;
          enc   = 2'd0;
          for (i = 0; i < len; i++) begin
            u    = 1'($urandom_range(0, 1));
            ns   = {u, enc[1]};
            code = CodeTab[ns][enc[0]];
            if ($urandom_range(0, 15) < pf) code[1] = ~code[1];
            if ($urandom_range(0, 15) < pf) code[0] = ~code[0];
            push_pair(code[1], code[0], close && (i == len - 1));
            enc = ns;
          end
        end else begin
          // noise, possibly broken early, always ending on a flush
          len = $urandom_range(1, 12);
          for (i = 0; i < len; i++)
            push_pair(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      (i == len - 1) || ($urandom_range(0, 7) == 0));
        end
      end
    end

    wait_drained();
    if (err_cnt == 0) begin
      $display("viterbi_decoder_k3_rate_half_unit_tb: done, clean");
    end else begin
      $display("viterbi_decoder_k3_rate_half_unit_tb: done, errors");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/vdk3_pkg.sv
rtl/vdk3_if.sv
rtl/vdk3_front.sv
rtl/vdk3_queue.sv
rtl/vdk3_back.sv
rtl/viterbi_decoder_k3_rate_half_unit.sv
rtl/vdk3_checker.sv
tb/viterbi_decoder_k3_rate_half_unit_tb.sv
